// ===== design/kscl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan code lock package
// Shared widths, register indexes, lock codes and types for the keypad
// scanner and its code lock sequencer.
// ----------------------------------------------------------------------------
package kscl_pkg;

  // Number of code keys in use
  localparam int CODE_LEN = 11;
  // Index width for the code digit counter
  localparam int DIGIT_W  = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

  localparam int KEY_W    = 4;
  localparam int ROW_W    = 2;
  localparam int COL_N    = 4;
  localparam int MAP_W    = 16;
  localparam int STATE_W  = 4;
  localparam int CODE_W   = 44;
  localparam int CFG_W    = CODE_W;
  localparam int IDX_W    = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CODE_KEYS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CONFIRM_KEY = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLEAR_KEY   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CODE_W-1:0] CODE_KEYS_RST   = 44'hF5F_FF5F_DAD9;
  localparam logic [KEY_W-1:0]  CONFIRM_KEY_RST = 4'd3;
  localparam logic [KEY_W-1:0]  CLEAR_KEY_RST   = 4'd0;

  // Reported lock state codes beyond the digit count
  localparam logic [STATE_W-1:0] ST_CONFIRM = 4'd11;
  localparam logic [STATE_W-1:0] ST_ERROR   = 4'd12;
  localparam logic [STATE_W-1:0] ST_OPEN    = 4'd13;

  typedef enum logic [3:0] {
    PH_ENTRY   = 4'b0001,
    PH_CONFIRM = 4'b0010,
    PH_ERROR   = 4'b0100,
    PH_OPEN    = 4'b1000
  } lock_phase_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_keys;
    logic [KEY_W-1:0]  confirm_key;
    logic [KEY_W-1:0]  clear_key;
  } lock_cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] lock_state;
    logic               unlocked;
  } lock_status_t;

  function automatic logic [MAP_W-1:0] key_onehot(input logic [KEY_W-1:0] key);
    logic [MAP_W-1:0] v;
    v = '0;
    v[key] = 1'b1;
    return v;
  endfunction

endpackage

// ===== design/kscl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan code lock channel interfaces
// Valid/ready channels for scan ticks in and scan results out.
// ----------------------------------------------------------------------------
interface kscl_scan_if import kscl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_N-1:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink   (input valid, input column_levels, output ready);
endinterface

interface kscl_result_if import kscl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_drive;
  logic [MAP_W-1:0]   key_map;
  logic               press_event;
  logic [STATE_W-1:0] lock_state;
  logic               unlocked;

  modport source (output valid, output row_drive, output key_map, output press_event,
                  output lock_state, output unlocked, input ready);
  modport sink   (input valid, input row_drive, input key_map, input press_event,
                  input lock_state, input unlocked, output ready);
endinterface

// ===== design/keypad_scan_code_lock_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan code lock
// 4x4 matrix keypad scanner with an eleven-key code lock sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   scan   - one transaction per scan tick, carrying the active-low column
//            levels of the row driven during that tick.
//   result - one transaction per scan tick: the row to drive next, the
//            pressed-key map, the press event flag and the lock status.
//   wr_en / wr_index / wr_data - configuration writes (code keys, confirm
//            key, clear key); write only while the block is idle.
// An accepted scan transaction's result is registered and offered in the next cycle.
// Throughput is one transaction per cycle while the receiver does not stall:
// the map update and the lock transition are a single combinational pass
// into the result register, and that register is the only stage.
// Reset clears the row counter, the key map and the lock (no keys matched)
// and restores the default code, confirm and clear keys.
// When the receiver stalls the result register holds; scan stays ready while
// the held result is being taken in the same cycle.
// ----------------------------------------------------------------------------
module keypad_scan_code_lock_top import kscl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [CFG_W-1:0]    wr_data,
  kscl_scan_if.sink           scan,
  kscl_result_if.source       result
);

  lock_cfg_t          cfg;
  logic [ROW_W-1:0]   row;
  logic [ROW_W-1:0]   row_next;
  logic [MAP_W-1:0]   map;
  logic [MAP_W-1:0]   map_next;
  logic               press_next;
  logic               accept;
  lock_status_t       status_next;

  // Hand over when the result register is empty or being drained
  assign scan.ready = !result.valid || result.ready;
  assign accept     = scan.valid && scan.ready;

  // Configuration registers: ignore writes to indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_keys   <= CODE_KEYS_RST;
      cfg.confirm_key <= CONFIRM_KEY_RST;
      cfg.clear_key   <= CLEAR_KEY_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CODE_KEYS:   cfg.code_keys   <= wr_data[CODE_W-1:0];
        REG_CONFIRM_KEY: cfg.confirm_key <= wr_data[KEY_W-1:0];
        REG_CLEAR_KEY:   cfg.clear_key   <= wr_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Replace the nibble of the driven row with the inverted column levels
  always_comb begin
    map_next = map;
    map_next[row*COL_N +: COL_N] = ~scan.column_levels;
    row_next   = row + 1'b1;
    press_next = (map == '0) && (map_next != '0);
  end

  kscl_lock_seq u_lock_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept && press_next),
    .key_map     (map_next),
    .cfg         (cfg),
    .status_next (status_next)
  );

  // Scanner state: advance only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      map <= '0;
    end else if (accept) begin
      row <= row_next;
      map <= map_next;
    end
  end

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.row_drive   <= row_next;
      result.key_map     <= map_next;
      result.press_event <= press_next;
      result.lock_state  <= status_next.lock_state;
      result.unlocked    <= status_next.unlocked;
    end
  end

  // The row counter advances by exactly one per accepted tick
  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    accept |=> (row == $past(row) + 2'd1))
    else $error("row counter did not advance on scan transaction");

  // A press event always comes with a nonempty key map
  a_press_map: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.press_event) |-> (result.key_map != '0))
    else $error("press event with empty key map");

  // The open flag agrees with the reported lock state
  a_unlocked: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.unlocked == (result.lock_state == ST_OPEN)))
    else $error("unlocked flag disagrees with lock state");

  // A stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.key_map)))
    else $error("stalled result changed");

endmodule

// ===== design/kscl_lock_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan code lock sequencer
// Holds the lock phase and digit count; advances on each press event and
// presents the status that follows the current transaction.
// ----------------------------------------------------------------------------
module kscl_lock_seq import kscl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [MAP_W-1:0] key_map,
  input  lock_cfg_t        cfg,
  output lock_status_t     status_next
);

  lock_phase_t        phase, phase_next;
  logic [DIGIT_W-1:0] digit, digit_next;
  logic [KEY_W-1:0]   code_digit [CODE_LEN];
  logic [MAP_W-1:0]   clr_map;
  logic [MAP_W-1:0]   want_map;

  for (genvar i = 0; i < CODE_LEN; i++) begin : g_digit
    assign code_digit[i] = cfg.code_keys[KEY_W*i +: KEY_W];
  end

  assign clr_map  = key_onehot(cfg.clear_key);
  assign want_map = key_onehot(code_digit[digit]);

  always_comb begin
    phase_next = phase;
    digit_next = digit;
    if (advance) begin
      unique case (phase)
        PH_ENTRY: begin
          if ((digit == '0) && (key_map == clr_map)) begin
            digit_next = '0;
          end else if (key_map == want_map) begin
            if (digit == DIGIT_W'(CODE_LEN - 1)) begin
              phase_next = PH_CONFIRM;
              digit_next = '0;
            end else begin
              digit_next = digit + 1'b1;
            end
          end else begin
            phase_next = PH_ERROR;
            digit_next = '0;
          end
        end
        PH_CONFIRM: begin
          phase_next = (key_map == key_onehot(cfg.confirm_key)) ? PH_OPEN : PH_ERROR;
        end
        PH_ERROR: begin
          if (key_map == clr_map) begin
            phase_next = PH_ENTRY;
            digit_next = '0;
          end
        end
        PH_OPEN: begin
          if (key_map == clr_map) phase_next = PH_ERROR;
        end
        default: begin
          phase_next = PH_ERROR;
          digit_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_next)
      PH_ENTRY:   status_next.lock_state = STATE_W'(digit_next);
      PH_CONFIRM: status_next.lock_state = ST_CONFIRM;
      PH_OPEN:    status_next.lock_state = ST_OPEN;
      default:    status_next.lock_state = ST_ERROR;
    endcase
    status_next.unlocked = (phase_next == PH_OPEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ENTRY;
      digit <= '0;
    end else begin
      phase <= phase_next;
      digit <= digit_next;
    end
  end

endmodule

// ===== dv/kscl_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan code lock result checker
// Follows the scan transactions and configuration writes, keeps its own copy
// of the row counter, key map and lock sequencer, and compares every result
// transaction with the oldest predicted result.
// ----------------------------------------------------------------------------
module kscl_result_checker import kscl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  kscl_scan_if             scan,
  kscl_result_if           result,
  output int               fail_count
);

  localparam logic [STATE_W-1:0] ST_START = '0;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [ROW_W-1:0]   row_drive;
    logic [MAP_W-1:0]   key_map;
    logic               press_event;
    logic [STATE_W-1:0] lock_state;
    logic               unlocked;
  } scan_result_t;

  logic [CODE_W-1:0]  code_reg;
  logic [KEY_W-1:0]   confirm_reg;
  logic [KEY_W-1:0]   clear_reg;
  logic [ROW_W-1:0]   row_q;
  logic [MAP_W-1:0]   map_q;
  logic [STATE_W-1:0] lock_q;

  scan_result_t pending_results[$];
  int mismatches  = 0;
  int outstanding = 0;

  // Anything still waiting at the end counts against the run
  assign fail_count = mismatches + outstanding;

  function automatic logic [MAP_W-1:0] key_bit(input logic [KEY_W-1:0] key);
    return MAP_W'(1) << key;
  endfunction

  // Lock transition on a press event, given the map seen at that tick
  function automatic logic [STATE_W-1:0] lock_next_state(input logic [STATE_W-1:0] st,
                                                         input logic [MAP_W-1:0]   m);
    logic [KEY_W-1:0] digit;
    if (int'(st) < CODE_LEN) begin
      digit = KEY_W'(code_reg >> (KEY_W * int'(st)));
      if (st == ST_START && m == key_bit(clear_reg)) return ST_START;
      if (m != key_bit(digit)) return ST_ERROR;
      return (int'(st) + 1 == CODE_LEN) ? ST_CONFIRM : st + 1'b1;
    end
    case (st)
      ST_CONFIRM: return (m == key_bit(confirm_reg)) ? ST_OPEN : ST_ERROR;
      ST_ERROR:   return (m == key_bit(clear_reg)) ? ST_START : ST_ERROR;
      ST_OPEN:    return (m == key_bit(clear_reg)) ? ST_ERROR : ST_OPEN;
      default:    return ST_ERROR;
    endcase
  endfunction

  function automatic string describe(input scan_result_t r);
    return $sformatf("row %0d map %h event %0b state %0d unlocked %0b",
                     r.row_drive, r.key_map, r.press_event, r.lock_state, r.unlocked);
  endfunction

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    logic [MAP_W-1:0] next_map;
    if (rst) begin
      code_reg    = CODE_KEYS_RST;
      confirm_reg = CONFIRM_KEY_RST;
      clear_reg   = CLEAR_KEY_RST;
      row_q       = '0;
      map_q       = '0;
      lock_q      = ST_START;
      pending_results.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_CODE_KEYS:   code_reg    = wr_data[CODE_W-1:0];
          REG_CONFIRM_KEY: confirm_reg = wr_data[KEY_W-1:0];
          REG_CLEAR_KEY:   clear_reg   = wr_data[KEY_W-1:0];
          default: ;
        endcase
      end

      // Retire first: a result taken now belongs to an earlier scan tick
      if (result.valid && result.ready) begin
        got.row_drive   = result.row_drive;
        got.key_map     = result.key_map;
        got.press_event = result.press_event;
        got.lock_state  = result.lock_state;
        got.unlocked    = result.unlocked;
        if (pending_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result: %s", describe(got));
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_MAX)
              $display("result mismatch: expected %s, got %s", describe(want), describe(got));
            mismatches++;
          end
        end
      end

      if (scan.valid && scan.ready) begin
        next_map = map_q;
        next_map[row_q*COL_N +: COL_N] = ~scan.column_levels;
        want.press_event = (map_q == '0) && (next_map != '0);
        if (want.press_event) lock_q = lock_next_state(lock_q, next_map);
        row_q          = row_q + 1'b1;
        map_q          = next_map;
        want.row_drive  = row_q;
        want.key_map    = map_q;
        want.lock_state = lock_q;
        want.unlocked   = (lock_q == ST_OPEN);
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan code lock testbench
// Drives scan ticks that model key presses on the 4x4 matrix: a short
// directed opening, then code entry attempts with random keys, wrong digits,
// confirms and relocks, mixed with noise and multi-key presses, across
// several code, confirm and clear key settings. Both channels idle in random
// bursts except in the last phase. The checker beside the block predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
  import kscl_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 5;
  localparam int QUIET_LIMIT = 500;  // cycles with no transaction on either side
  localparam int PHASES      = 7;    // phase 0 runs on the reset settings
  localparam int PHASE_TICKS = 30;   // scan ticks per phase, roughly
  localparam int TAIL_CYCLES = 4;

  logic             clk = 1'b0;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  kscl_scan_if   scan();
  kscl_result_if result();

  int fail_count;
  int ticks_sent   = 0;  // scan transactions accepted so far
  int results_seen = 0;  // result transactions accepted so far
  int quiet_cycles = 0;
  bit idling       = 1'b1;

  // Stimulus-side copy of the settings, used only to pick keys to press
  logic [CODE_W-1:0] code_keys;
  logic [KEY_W-1:0]  confirm_key;
  logic [KEY_W-1:0]  clear_key;

  keypad_scan_code_lock_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .scan     (scan),
    .result   (result)
  );

  kscl_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .scan       (scan),
    .result     (result),
    .fail_count (fail_count)
  );

  always #CLK_HALF clk = ~clk;

  // Count results and guard against a hang: any transaction resets the count
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
      quiet_cycles <= 0;
    end else begin
      if (result.valid && result.ready) results_seen <= results_seen + 1;
      if ((scan.valid && scan.ready) || (result.valid && result.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: take results, stalling in random bursts while idling is on
  initial begin
    result.ready <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      result.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Offer one scan tick and hold it until accepted. Ready is sampled at the
  // falling edge, where every input and output is settled for the next rise.
  task automatic send_tick(input logic [COL_N-1:0] levels);
    bit took;
    if (idling && $urandom_range(0, 4) == 0) begin
      scan.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    scan.valid         <= 1'b1;
    scan.column_levels <= levels;
    do begin
      @(negedge clk);
      took = scan.ready;
      @(posedge clk);
    end while (!took);
    ticks_sent++;
  endtask

  // One full scan of released keys: every row reads back empty, so the map
  // is clear and the next press can raise a press event
  task automatic release_all();
    repeat (1 << ROW_W) send_tick('1);
  endtask

  // Wait for the row to come round, drive its columns once, then release
  task automatic press_levels(input logic [ROW_W-1:0] row, input logic [COL_N-1:0] levels);
    while (ROW_W'(ticks_sent) != row) send_tick('1);
    send_tick(levels);
    release_all();
  endtask

  // Key index is row*4+column, so the top bits pick the row
  task automatic press_key(input logic [KEY_W-1:0] key);
    logic [COL_N-1:0] levels;
    levels = '1;
    levels[key[1:0]] = 1'b0;
    press_levels(key[KEY_W-1:2], levels);
  endtask

  // Two clears bring any state back to the start of entry (open relocks to
  // error first), then enter the code, now and then with one digit wrong
  task automatic code_attempt();
    int digits;
    int wrong_at;
    logic [KEY_W-1:0] key;
    press_key(clear_key);
    press_key(clear_key);
    wrong_at = -1;
    case ($urandom_range(0, 3))
      0: wrong_at = CODE_LEN - 1;
      1: wrong_at = $urandom_range(0, CODE_LEN - 1);
      default: ;
    endcase
    digits = (wrong_at >= 0) ? wrong_at + 1 : CODE_LEN;
    for (int i = 0; i < digits; i++) begin
      key = code_keys[i*KEY_W +: KEY_W];
      if (i == wrong_at) key = key + KEY_W'($urandom_range(1, 15));
      press_key(key);
    end
    if (wrong_at < 0) begin
      if ($urandom_range(0, 4) == 0) press_key(confirm_key + KEY_W'($urandom_range(1, 15)));
      else press_key(confirm_key);
      // a stray key while open or in error, then maybe relock
      if ($urandom_range(0, 1) == 1) press_key(KEY_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 1) == 1) press_key(clear_key);
    end
  endtask

  task automatic run_sequence();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      code_attempt();
    end else if (pick == 7) begin
      // raw noise on whatever rows come up
      repeat ($urandom_range(1, 8)) send_tick(COL_N'($urandom_range(0, 15)));
      release_all();
    end else if (pick == 8) begin
      press_levels(ROW_W'($urandom_range(0, 3)), COL_N'($urandom_range(0, 15)));
    end else begin
      press_key(KEY_W'($urandom_range(0, 15)));
    end
  endtask

  // Hold until every accepted tick has produced its result
  task automatic wait_drained();
    while (results_seen != ticks_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
  endtask

  initial begin
    int phase_start;
    rst                <= 1'b1;
    wr_en              <= 1'b0;
    wr_index           <= REG_CODE_KEYS;
    wr_data            <= '0;
    scan.valid         <= 1'b0;
    scan.column_levels <= '1;
    code_keys   = CODE_KEYS_RST;
    confirm_key = CONFIRM_KEY_RST;
    clear_key   = CLEAR_KEY_RST;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed opening on the reset settings:
    // whole row pressed at once, a wrong key from the start state
    press_levels('0, '0);
    // clear leaves error, then a clear in the start state stays put
    press_key(clear_key);
    press_key(clear_key);
    // first code digit, then the clear key during entry counts as wrong
    press_key(code_keys[KEY_W-1:0]);
    press_key(clear_key);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // Drop valid and let the block drain before touching the settings
        scan.valid <= 1'b0;
        wait_drained();
        case (phase)
          1: begin
            code_keys   = '0;
            confirm_key = '0;
            clear_key   = '1;
          end
          2: begin
            code_keys   = '1;
            confirm_key = '1;
            clear_key   = '0;
          end
          default: begin
            code_keys   = CODE_W'({$urandom, $urandom});
            confirm_key = KEY_W'($urandom_range(0, 15));
            clear_key   = KEY_W'($urandom_range(0, 15));
          end
        endcase
        write_reg(REG_CODE_KEYS, CFG_W'(code_keys));
        write_reg(REG_CONFIRM_KEY, CFG_W'(confirm_key));
        write_reg(REG_CLEAR_KEY, CFG_W'(clear_key));
        wr_en <= 1'b0;
      end
      // Run the last phase at full rate on both sides
      if (phase == PHASES - 1) idling = 1'b0;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) run_sequence();
    end

    scan.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/kscl_pkg.sv
design/kscl_if.sv
design/kscl_lock_seq.sv
design/keypad_scan_code_lock_top.sv
dv/kscl_result_checker.sv
dv/tb.sv
